// File: hw/rtl/rwg_pkg.sv
// Shared types and constants for the replay window guard.
package rwg_pkg;

    typedef logic [2:0] verdict_t;
    localparam verdict_t V_ACCEPTED  = 3'd0;
    localparam verdict_t V_GAP       = 3'd1;
    localparam verdict_t V_DUPLICATE = 3'd2;
    localparam verdict_t V_TOO_OLD   = 3'd3;
    localparam verdict_t V_EPOCH     = 3'd4;
    localparam verdict_t V_NO_EPOCH  = 3'd5;
    localparam verdict_t V_RECORDED  = 3'd6;
    localparam verdict_t V_NOT_FOUND = 3'd7;

    localparam logic CMD_CHECK  = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_EPOCH_UPPER   = 3'd0;
    localparam reg_idx_t REG_EPOCH_LOWER   = 3'd1;
    localparam reg_idx_t REG_EPOCH_VALID   = 3'd2;
    localparam reg_idx_t REG_ACCEPTED_CODE = 3'd3;
    localparam reg_idx_t REG_DUP_CODE      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SHIFT,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0] seq;
        logic [63:0] prefix;
        logic [7:0]  code;
    } cache_entry_t;

    typedef struct packed {
        logic start;
        logic record;
        logic push;
    } cache_req_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [7:0] code;
    } cache_resp_t;

endpackage

// File: hw/rtl/rwg_cache.sv
// Result cache: FIFO-written memory with a sequential lookup walk.
module rwg_cache
    import rwg_pkg::*;
#(
    parameter int CACHE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        clear,
    input  cache_req_t  req,
    input  logic [63:0] key_seq,
    input  logic [63:0] key_prefix,
    input  logic [7:0]  wr_code,
    output cache_resp_t resp
);

    localparam int PW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

    cache_entry_t mem [CACHE_DEPTH];
    cache_entry_t rd_reg;

    logic [CACHE_DEPTH-1:0] used_reg;
    logic [PW-1:0]          wptr_reg;
    logic [PW:0]            issue_reg;
    logic                   active_reg;
    logic                   record_reg;
    logic                   chk_valid_reg;
    logic [PW-1:0]          chk_idx_reg;

    logic          match;
    logic          last;
    logic          done;
    logic          issue;
    logic [PW-1:0] rd_addr;

    assign rd_addr = issue_reg[PW-1:0];
    assign issue   = active_reg && (issue_reg < (PW+1)'(CACHE_DEPTH));
    assign match   = chk_valid_reg && used_reg[chk_idx_reg] && (rd_reg.seq == key_seq)
                     && (!record_reg || (rd_reg.prefix == key_prefix));
    assign last    = chk_idx_reg == PW'(CACHE_DEPTH - 1);
    assign done    = chk_valid_reg && (match || last);

    assign resp.done  = done;
    assign resp.found = match;
    assign resp.code  = rd_reg.code;

    always_ff @(posedge aclk) begin
        if (req.push) begin
            mem[wptr_reg] <= '{seq: key_seq, prefix: key_prefix, code: wr_code};
        end else if (match && record_reg) begin
            mem[chk_idx_reg] <= '{seq: rd_reg.seq, prefix: rd_reg.prefix, code: wr_code};
        end
        if (issue) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            wptr_reg      <= '0;
            issue_reg     <= '0;
            active_reg    <= 1'b0;
            record_reg    <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
        end else begin
            if (clear) begin
                used_reg <= '0;
                wptr_reg <= '0;
            end else if (req.push) begin
                used_reg[wptr_reg] <= 1'b1;
                wptr_reg <= (wptr_reg == PW'(CACHE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (req.start) begin
                active_reg    <= 1'b1;
                record_reg    <= req.record;
                issue_reg     <= '0;
                chk_valid_reg <= 1'b0;
            end else if (done) begin
                active_reg    <= 1'b0;
                chk_valid_reg <= 1'b0;
            end else begin
                chk_valid_reg <= issue;
                if (issue) begin
                    chk_idx_reg <= rd_addr;
                    issue_reg   <= issue_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/replay_window_guard.sv
// Anti-replay guard: sequencer, seen window, output register and APB registers.
// Path: a check decided at once passes ST_DECIDE and ST_FINISH before m_valid; a window
// slide adds log2(WINDOW_BITS) shift steps; a duplicate or record walks the cache,
// one entry per cycle through the cache read port.
// Throughput: one beat at a time; s_ready is high only while the sequencer is idle.
// Reset (aresetn, synchronous, low): registers to defaults, window and cache empty.
module replay_window_guard
    import rwg_pkg::*;
#(
    parameter int WINDOW_BITS = 128,
    parameter int CACHE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [63:0] s_epoch_hi,
    input  logic [63:0] s_epoch_lo,
    input  logic [63:0] s_sequence_req,
    input  logic [63:0] s_request_prefix,
    input  logic [7:0]  s_result_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [7:0]  m_cached_code
);

    localparam int IW = $clog2(WINDOW_BITS);
    localparam int SW = (IW > 1) ? $clog2(IW) : 1;

    // configuration
    logic [63:0] epoch_upper_reg;
    logic [63:0] epoch_lower_reg;
    logic        epoch_valid_reg;
    logic [7:0]  accepted_code_reg;
    logic [7:0]  dup_code_reg;
    logic        cfg_wr;
    logic        clear;
    reg_idx_t    cfg_idx;

    // sequencer
    state_t           state_reg, state_next;
    logic             cmd_reg;
    logic [63:0]      ehi_reg, elo_reg, seq_reg, prefix_reg;
    logic [7:0]       rcode_reg;
    logic [63:0]      highest_reg, highest_next;
    logic             seen_reg, seen_next;
    logic [WINDOW_BITS-1:0] window_reg, window_next, shifted;
    logic [IW-1:0]    delta_reg, delta_next;
    logic [SW-1:0]    step_reg, step_next;
    verdict_t         res_verdict_reg, res_verdict_next;
    logic [7:0]       res_code_reg, res_code_next;
    logic             m_valid_reg, m_valid_next;
    verdict_t         m_verdict_reg, m_verdict_next;
    logic [7:0]       m_code_reg, m_code_next;

    logic [64:0]  up_diff;
    logic [63:0]  dn_diff;
    cache_req_t   creq;
    cache_resp_t  cresp;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign clear   = cfg_wr && ((cfg_idx == REG_EPOCH_UPPER) || (cfg_idx == REG_EPOCH_LOWER));

    always_comb begin
        case (cfg_idx)
            REG_EPOCH_UPPER:   prdata = epoch_upper_reg;
            REG_EPOCH_LOWER:   prdata = epoch_lower_reg;
            REG_EPOCH_VALID:   prdata = {63'd0, epoch_valid_reg};
            REG_ACCEPTED_CODE: prdata = {56'd0, accepted_code_reg};
            REG_DUP_CODE:      prdata = {56'd0, dup_code_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_upper_reg   <= '0;
            epoch_lower_reg   <= '0;
            epoch_valid_reg   <= 1'b0;
            accepted_code_reg <= '0;
            dup_code_reg      <= 8'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_EPOCH_UPPER:   epoch_upper_reg   <= pwdata;
                REG_EPOCH_LOWER:   epoch_lower_reg   <= pwdata;
                REG_EPOCH_VALID:   epoch_valid_reg   <= pwdata[0];
                REG_ACCEPTED_CODE: accepted_code_reg <= pwdata[7:0];
                REG_DUP_CODE:      dup_code_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_verdict     = m_verdict_reg;
    assign m_cached_code = m_code_reg;

    // seq - highest and highest - seq, side by side
    assign up_diff = {1'b0, seq_reg} - {1'b0, highest_reg};
    assign dn_diff = highest_reg - seq_reg;
    // one power-of-two slide step per cycle
    assign shifted = delta_reg[step_reg] ? (window_reg << (32'd1 << step_reg)) : window_reg;

    always_comb begin
        state_next       = state_reg;
        highest_next     = highest_reg;
        seen_next        = seen_reg;
        window_next      = window_reg;
        delta_next       = delta_reg;
        step_next        = step_reg;
        res_verdict_next = res_verdict_reg;
        res_code_next    = res_code_reg;
        m_valid_next     = m_valid_reg;
        m_verdict_next   = m_verdict_reg;
        m_code_next      = m_code_reg;
        creq             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_code_next = '0;
                state_next    = ST_FINISH;
                if (cmd_reg == CMD_RECORD) begin
                    creq.start  = 1'b1;
                    creq.record = 1'b1;
                    state_next  = ST_WALK;
                end else if (!epoch_valid_reg) begin
                    res_verdict_next = V_NO_EPOCH;
                end else if (ehi_reg != epoch_upper_reg || elo_reg != epoch_lower_reg) begin
                    res_verdict_next = V_EPOCH;
                end else if (!seen_reg) begin
                    window_next      = WINDOW_BITS'(1);
                    highest_next     = seq_reg;
                    seen_next        = 1'b1;
                    creq.push        = 1'b1;
                    res_verdict_next = V_ACCEPTED;
                end else if (!up_diff[64] && up_diff[63:0] != 64'd0) begin
                    highest_next     = seq_reg;
                    creq.push        = 1'b1;
                    res_verdict_next = V_ACCEPTED;
                    if (up_diff[63:0] >= 64'(WINDOW_BITS)) begin
                        window_next = WINDOW_BITS'(1);
                    end else begin
                        delta_next = up_diff[IW-1:0];
                        step_next  = '0;
                        state_next = ST_SHIFT;
                    end
                end else if (dn_diff >= 64'(WINDOW_BITS)) begin
                    res_verdict_next = V_TOO_OLD;
                end else if (window_reg[dn_diff[IW-1:0]]) begin
                    creq.start = 1'b1;
                    state_next = ST_WALK;
                end else begin
                    window_next[dn_diff[IW-1:0]] = 1'b1;
                    creq.push        = 1'b1;
                    res_verdict_next = V_GAP;
                end
            end
            ST_SHIFT: begin
                window_next = shifted;
                step_next   = step_reg + 1'b1;
                if (step_reg == SW'(IW - 1)) begin
                    window_next = shifted | WINDOW_BITS'(1);
                    state_next  = ST_FINISH;
                end
            end
            ST_WALK: begin
                if (cresp.done) begin
                    state_next = ST_FINISH;
                    if (cmd_reg == CMD_RECORD) begin
                        res_verdict_next = cresp.found ? V_RECORDED : V_NOT_FOUND;
                        res_code_next    = '0;
                    end else begin
                        res_verdict_next = V_DUPLICATE;
                        res_code_next    = cresp.found ? cresp.code : dup_code_reg;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = res_verdict_reg;
                    m_code_next    = res_code_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (clear) begin
            highest_next = '0;
            seen_next    = 1'b0;
            window_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            highest_reg <= '0;
            seen_reg    <= 1'b0;
            window_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            highest_reg <= highest_next;
            seen_reg    <= seen_next;
            window_reg  <= window_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_command;
            ehi_reg    <= s_epoch_hi;
            elo_reg    <= s_epoch_lo;
            seq_reg    <= s_sequence_req;
            prefix_reg <= s_request_prefix;
            rcode_reg  <= s_result_code;
        end
        delta_reg       <= delta_next;
        step_reg        <= step_next;
        res_verdict_reg <= res_verdict_next;
        res_code_reg    <= res_code_next;
        m_verdict_reg   <= m_verdict_next;
        m_code_reg      <= m_code_next;
    end

    rwg_cache #(
        .CACHE_DEPTH(CACHE_DEPTH)
    ) u_cache (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (clear),
        .req        (creq),
        .key_seq    (seq_reg),
        .key_prefix (prefix_reg),
        .wr_code    (creq.push ? accepted_code_reg : rcode_reg),
        .resp       (cresp)
    );

endmodule

// File: bench/replay_window_guard_test.sv
// Self-checking testbench for replay_window_guard: directed table, random traffic, scoreboard.
module replay_window_guard_test;
    import rwg_pkg::*;

    localparam reg_idx_t REG_UNMAPPED = 3'd5;
    localparam int WIN = 128;
    localparam int DEPTH = 32;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic        cmd;
        logic [63:0] ehi;
        logic [63:0] elo;
        logic [63:0] seq;
        logic [63:0] pfx;
        logic [7:0]  rc;
        bit          typed;
        verdict_t    v;
        logic [7:0]  code;
    } row_t;

    typedef struct {
        verdict_t   v;
        logic [7:0] code;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    logic        s_valid, s_ready, s_command;
    logic [63:0] s_epoch_hi, s_epoch_lo, s_sequence_req, s_request_prefix;
    logic [7:0]  s_result_code;
    logic        m_valid, m_ready;
    logic [2:0]  m_verdict;
    logic [7:0]  m_cached_code;

    replay_window_guard u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // guard model state and registers
    logic [63:0]  ep_upper, ep_lower;
    logic         ep_valid;
    logic [7:0]   acc_code, dup_code;
    logic [63:0]  top_seq;
    logic         any_seen;
    logic [WIN-1:0] seen_bits;
    logic [63:0]  c_seq [DEPTH];
    logic [63:0]  c_pfx [DEPTH];
    logic [7:0]   c_code [DEPTH];
    logic [DEPTH-1:0] c_used;
    int           c_wp;

    answer_t      answers_due[$];
    logic [63:0]  hist_seq[$];
    logic [63:0]  hist_pfx[$];
    int           errors = 0;
    int           beats_in = 0, beats_out = 0;
    int           verdict_hits[8];
    bit           hold_req = 0;
    bit           burst = 0;

    task automatic report(input string msg);
        $display("ERROR t=%0t %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_tracking();
        top_seq = '0;
        any_seen = 1'b0;
        seen_bits = '0;
        c_used = '0;
        c_wp = 0;
    endfunction

    function automatic void cache_push(input logic [63:0] seq, input logic [63:0] pfx);
        c_seq[c_wp] = seq;
        c_pfx[c_wp] = pfx;
        c_code[c_wp] = acc_code;
        c_used[c_wp] = 1'b1;
        c_wp = (c_wp + 1) % DEPTH;
        hist_seq.push_back(seq);
        hist_pfx.push_back(pfx);
        if (hist_seq.size() > 48) begin
            void'(hist_seq.pop_front());
            void'(hist_pfx.pop_front());
        end
    endfunction

    function automatic answer_t guard_decide(input logic cmd, input logic [63:0] ehi,
                                             input logic [63:0] elo, input logic [63:0] seq,
                                             input logic [63:0] pfx, input logic [7:0] rc);
        answer_t a;
        logic [63:0] delta;
        a.code = '0;
        if (cmd == CMD_RECORD) begin
            a.v = V_NOT_FOUND;
            for (int i = 0; i < DEPTH; i++) begin
                if (c_used[i] && c_seq[i] == seq && c_pfx[i] == pfx) begin
                    c_code[i] = rc;
                    a.v = V_RECORDED;
                    break;
                end
            end
        end else if (!ep_valid) begin
            a.v = V_NO_EPOCH;
        end else if (ehi != ep_upper || elo != ep_lower) begin
            a.v = V_EPOCH;
        end else if (!any_seen) begin
            seen_bits = '0;
            seen_bits[0] = 1'b1;
            top_seq = seq;
            any_seen = 1'b1;
            cache_push(seq, pfx);
            a.v = V_ACCEPTED;
        end else if (seq > top_seq) begin
            delta = seq - top_seq;
            seen_bits = (delta >= WIN) ? '0 : seen_bits << delta[6:0];
            seen_bits[0] = 1'b1;
            top_seq = seq;
            cache_push(seq, pfx);
            a.v = V_ACCEPTED;
        end else begin
            delta = top_seq - seq;
            if (delta >= WIN) begin
                a.v = V_TOO_OLD;
            end else if (seen_bits[delta[6:0]]) begin
                a.v = V_DUPLICATE;
                a.code = dup_code;
                for (int i = 0; i < DEPTH; i++) begin
                    if (c_used[i] && c_seq[i] == seq) begin
                        a.code = c_code[i];
                        break;
                    end
                end
            end else begin
                seen_bits[delta[6:0]] = 1'b1;
                cache_push(seq, pfx);
                a.v = V_GAP;
            end
        end
        return a;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_EPOCH_UPPER: begin ep_upper = val; clear_tracking(); end
            REG_EPOCH_LOWER: begin ep_lower = val; clear_tracking(); end
            REG_EPOCH_VALID: ep_valid = val[0];
            REG_ACCEPTED_CODE: acc_code = val[7:0];
            REG_DUP_CODE: dup_code = val[7:0];
            default: ;
        endcase
        // bus returns to idle between transfers
        @(posedge aclk);
    endtask

    task automatic drain();
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic configure(input logic [63:0] hi, input logic [63:0] lo, input logic vld,
                             input logic [7:0] acc, input logic [7:0] dup);
        drain();
        reg_write(REG_EPOCH_UPPER, hi);
        reg_write(REG_EPOCH_LOWER, lo);
        reg_write(REG_EPOCH_VALID, {63'd0, vld});
        reg_write(REG_ACCEPTED_CODE, {56'd0, acc});
        reg_write(REG_DUP_CODE, {56'd0, dup});
    endtask

    // drives one beat, waits for acceptance and queues its answer
    task automatic send_beat(input row_t r);
        int gap;
        answer_t a;
        gap = 0;
        if (!burst) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(20, 80);
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= r.cmd;
        s_epoch_hi <= r.ehi;
        s_epoch_lo <= r.elo;
        s_sequence_req <= r.seq;
        s_request_prefix <= r.pfx;
        s_result_code <= r.rc;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
        a = guard_decide(r.cmd, r.ehi, r.elo, r.seq, r.pfx, r.rc);
        if (r.typed) begin
            a.v = r.v;
            a.code = r.code;
        end
        answers_due.push_back(a);
    endtask

    function automatic row_t random_beat();
        row_t r;
        int k;
        r.typed = 0;
        r.v = V_ACCEPTED;
        r.code = '0;
        r.ehi = ep_upper;
        r.elo = ep_lower;
        r.rc = $urandom_range(0, 255);
        r.pfx = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                           : {56'h5EED_0000_0000_00, 8'($urandom_range(0, 3))};
        r.cmd = ($urandom_range(0, 4) == 0) ? CMD_RECORD : CMD_CHECK;
        case ($urandom_range(0, 99)) inside
            [0:44]: r.seq = top_seq + $urandom_range(1, 8);
            [45:54]: r.seq = top_seq + $urandom_range(100, 300);
            [55:84]: r.seq = top_seq - $urandom_range(0, 140);
            [85:86]: r.seq = {$urandom, $urandom};
            default: r.seq = top_seq - $urandom_range(0, 40);
        endcase
        if (hist_seq.size() != 0 && $urandom_range(0, 2) != 0 &&
            (r.cmd == CMD_RECORD || $urandom_range(0, 3) == 0)) begin
            k = $urandom_range(0, hist_seq.size() - 1);
            r.seq = hist_seq[k];
            if ($urandom_range(0, 5) != 0) r.pfx = hist_pfx[k];
        end
        case ($urandom_range(0, 19))
            0: r.ehi = {$urandom, $urandom};
            1: r.elo = ep_lower ^ (64'd1 << $urandom_range(0, 63));
            default: ;
        endcase
        return r;
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!burst && $urandom_range(0, 5) == 0)
                    stall = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        answer_t a;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            verdict_hits[m_verdict]++;
            if (answers_due.size() == 0) begin
                report($sformatf("result beat with none expected: verdict %0d", m_verdict));
            end else begin
                a = answers_due.pop_front();
                if (m_verdict !== a.v)
                    report($sformatf("verdict got %0d want %0d", m_verdict, a.v));
                if (m_cached_code !== a.code)
                    report($sformatf("cached_code got %0h want %0h", m_cached_code, a.code));
            end
        end
    end

    initial begin
        #8_000_000;
        $display("timeout: %0d beats in, %0d out", beats_in, beats_out);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        row_t dir[22];
        logic [63:0] p1, p2, p3;
        p1 = 64'h0102_0304_0506_0708;
        p2 = 64'hF0E1_D2C3_B4A5_9687;
        p3 = ALL_ONES;
        dir = '{
            '{CMD_CHECK, 0, 0, 1, p1, 0, 1, V_NO_EPOCH, 0},
            '{CMD_RECORD, 0, 0, 1, p1, 8'hFF, 1, V_NOT_FOUND, 0},
            '{CMD_CHECK, ALL_ONES, 1, 10, p1, 0, 1, V_EPOCH, 0},
            '{CMD_CHECK, 0, 0, 10, p1, 0, 1, V_EPOCH, 0},
            '{CMD_CHECK, ALL_ONES, 0, 0, p1, 8'hAA, 1, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 0, p1, 0, 0, V_ACCEPTED, 0},
            '{CMD_RECORD, 0, 0, 0, p1, 8'hFF, 1, V_RECORDED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 0, p1, 0, 0, V_ACCEPTED, 0},
            '{CMD_RECORD, ALL_ONES, 0, 0, p2, 8'h11, 1, V_NOT_FOUND, 0},
            '{CMD_CHECK, ALL_ONES, 0, 5, p2, 0, 1, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 3, p2, 0, 1, V_GAP, 0},
            '{CMD_CHECK, ALL_ONES, 0, 3, p2, 0, 0, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 132, p1, 0, 1, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 5, p1, 0, 0, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 4, p1, 0, 1, V_TOO_OLD, 0},
            '{CMD_CHECK, ALL_ONES, 0, 1000, p3, 0, 1, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 873, p3, 0, 1, V_GAP, 0},
            '{CMD_CHECK, ALL_ONES, 0, ALL_ONES, p2, 0, 1, V_ACCEPTED, 0},
            '{CMD_CHECK, ALL_ONES, 0, ALL_ONES - 1, p3, 0, 1, V_GAP, 0},
            '{CMD_RECORD, 0, 0, ALL_ONES - 1, p3, 8'h00, 1, V_RECORDED, 0},
            '{CMD_CHECK, ALL_ONES, 0, 0, p1, 0, 1, V_TOO_OLD, 0},
            '{CMD_CHECK, ALL_ONES, 0, ALL_ONES, p2, 0, 0, V_ACCEPTED, 0}
        };

        ep_upper = '0; ep_lower = '0; ep_valid = 1'b0; acc_code = '0; dup_code = 8'd1;
        clear_tracking();
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        s_valid <= 1'b0; s_command <= CMD_CHECK; s_epoch_hi <= '0; s_epoch_lo <= '0;
        s_sequence_req <= '0; s_request_prefix <= '0; s_result_code <= '0;
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 22; i++) begin
            if (i == 2) begin
                s_valid <= 1'b0;
                configure(ALL_ONES, 64'd0, 1'b1, 8'hA5, 8'h3C);
                reg_write(REG_UNMAPPED, ALL_ONES);
            end
            send_beat(dir[i]);
        end

        // random phases; phase 0 runs with no epoch provisioned
        for (int ph = 0; ph < 7; ph++) begin
            int n;
            s_valid <= 1'b0;
            case (ph)
                0: configure({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 8'h00, 8'hFF);
                1: configure(64'd0, 64'd0, 1'b1, 8'hFF, 8'h00);
                2: configure(ALL_ONES, ALL_ONES, 1'b1, 8'h5A, 8'hA5);
                default: configure({$urandom, $urandom}, {$urandom, $urandom}, 1'b1,
                                   8'($urandom), 8'($urandom));
            endcase
            n = (ph == 0) ? 40 : 290;
            burst = (ph == 3);
            if (ph == 4) hold_req = 1;
            for (int j = 0; j < n; j++) begin
                if (ph == 5 && j == 150) begin
                    s_valid <= 1'b0;
                    while (answers_due.size() != 0) @(posedge aclk);
                end
                send_beat(random_beat());
            end
            burst = 0;
        end
        s_valid <= 1'b0;

        while (answers_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d command beats over 8 register settings, %0d results checked",
                 beats_in, beats_out);
        $display("verdicts acc/gap/dup/old/epoch/noepoch/rec/nf: %0d %0d %0d %0d %0d %0d %0d %0d",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
                 verdict_hits[4], verdict_hits[5], verdict_hits[6], verdict_hits[7]);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/rwg_pkg.sv
hw/rtl/rwg_cache.sv
hw/rtl/replay_window_guard.sv
bench/replay_window_guard_test.sv
